/* hw/rtl/psev_pkg.sv */
// shared types and constants of the postfix stack evaluator
package psev_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef enum logic [2:0] {
		K_OTHER = 3'd0,
		K_DIGIT = 3'd1,
		K_ADD   = 3'd2,
		K_SUB   = 3'd3,
		K_MUL   = 3'd4,
		K_DIV   = 3'd5
	} kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] top_value;
		logic [PTR_W-1:0]              depth;
		logic [1:0]                    status;
	} out_item_t;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] digit;
		logic       start;
	} op_t;

	typedef struct packed {
		logic                   start;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [VALUE_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
	} div_rsp_t;

endpackage

/* hw/rtl/psev_ram.sv */
// generic single write port ram with registered read
module psev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/psev_front.sv */
// input register stage that accepts and classifies characters
module psev_front import psev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     char_valid,
	output logic     char_ready,
	input  in_item_t char_item,
	output logic     push,
	output op_t      push_op,
	input  logic     q_ready
);

	logic  v_s1;
	op_t   op_s1;
	op_t   dec;
	logic  acc;

	always_comb begin
		dec.start = char_item.start_req;
		dec.digit = 4'(char_item.char_code - CH_ZERO);
		if (char_item.char_code >= CH_ZERO && char_item.char_code <= CH_NINE) begin
			dec.kind = K_DIGIT;
		end else if (char_item.char_code == CH_PLUS) begin
			dec.kind = K_ADD;
		end else if (char_item.char_code == CH_MINUS) begin
			dec.kind = K_SUB;
		end else if (char_item.char_code == CH_STAR) begin
			dec.kind = K_MUL;
		end else if (char_item.char_code == CH_SLASH) begin
			dec.kind = K_DIV;
		end else begin
			dec.kind = K_OTHER;
		end
	end

	assign push       = v_s1 & q_ready;
	assign push_op    = op_s1;
	assign char_ready = ~v_s1 | q_ready;
	assign acc        = char_valid & char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc | (v_s1 & ~push);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= dec;
		end
	end

endmodule

/* hw/rtl/psev_queue.sv */
// two entry queue of classified items between front and back
module psev_queue import psev_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic ready,
	input  logic pop,
	output logic valid,
	output op_t  head
);

	op_t        ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign ready = cnt_q != 2'd2;
	assign valid = cnt_q != 2'd0;
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_op;
		end
	end

endmodule

/* hw/rtl/psev_div.sv */
// iterative signed divider, one quotient bit per cycle, truncating toward zero
module psev_div import psev_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int W     = VALUE_WIDTH;
	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic [W:0]       shifted;
	logic [W+1:0]     diff;
	logic             borrow;
	logic [W-1:0]     mag_a;
	logic [W-1:0]     mag_b;

	assign mag_a   = req.dividend[W-1] ? W'(-req.dividend) : req.dividend;
	assign mag_b   = req.divisor[W-1] ? W'(-req.divisor) : req.divisor;
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign borrow  = diff[W+1];

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? W'(-quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
		end else if (busy_q) begin
			rem_q <= borrow ? shifted[W-1:0] : diff[W-1:0];
			quo_q <= {quo_q[W-2:0], ~borrow};
		end
	end

endmodule

/* hw/rtl/psev_back.sv */
// execution sequencer: stack memory, top of stack register and result register
module psev_back import psev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  op_t       q_head,
	output logic      pop,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	localparam int W = VALUE_WIDTH;

	state_t           state_q;
	logic [PTR_W-1:0] sp_q;
	logic [PTR_W-1:0] sp_eff;
	logic [W-1:0]     tos_q;
	logic [1:0]       status_q;
	kind_t            kind_q;
	logic             res_valid_q;
	out_item_t        res_q;
	logic             is_op;
	logic             we;
	logic             re;
	logic [W-1:0]     rdata;
	div_req_t         dreq;
	div_rsp_t         drsp;
	logic             out_free;

	assign pop      = q_valid & (state_q == S_IDLE);
	assign sp_eff   = q_head.start ? '0 : sp_q;
	assign is_op    = q_head.kind == K_ADD || q_head.kind == K_SUB ||
	                  q_head.kind == K_MUL || q_head.kind == K_DIV;
	assign we       = pop & (q_head.kind == K_DIGIT) &
	                  (sp_eff != PTR_W'(STACK_DEPTH)) & (sp_eff != '0);
	assign re       = pop & is_op & (sp_eff >= PTR_W'(2));
	assign out_free = ~res_valid_q | res_ready;

	assign dreq.start    = (state_q == S_READ) & (kind_q == K_DIV) & (tos_q != '0);
	assign dreq.dividend = rdata;
	assign dreq.divisor  = tos_q;

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	psev_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(ADDR_W'(sp_eff - 1'b1)),
		.wdata(tos_q),
		.re   (re),
		.raddr(ADDR_W'(sp_eff - PTR_W'(2))),
		.rdata(rdata)
	);

	psev_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (dreq),
		.rsp   (drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (q_head.kind == K_DIGIT && sp_eff != PTR_W'(STACK_DEPTH)) begin
							sp_q <= sp_eff + 1'b1;
						end else begin
							sp_q <= sp_eff;
						end
						if (re) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_READ: begin
					if (kind_q == K_DIV) begin
						state_q <= (tos_q == '0) ? S_EMIT : S_DIV;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_DIV: begin
					if (drsp.done) begin
						sp_q    <= sp_q - 1'b1;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					kind_q <= q_head.kind;
					if (q_head.kind == K_DIGIT && sp_eff == PTR_W'(STACK_DEPTH)) begin
						status_q <= ST_OVER;
					end else if (is_op && !re) begin
						status_q <= ST_UNDER;
					end else begin
						status_q <= ST_OK;
					end
					if (q_head.kind == K_DIGIT && sp_eff != PTR_W'(STACK_DEPTH)) begin
						tos_q <= {{(W-4){1'b0}}, q_head.digit};
					end
				end
			end
			S_READ: begin
				unique case (kind_q)
					K_ADD: tos_q <= rdata + tos_q;
					K_SUB: tos_q <= rdata - tos_q;
					K_MUL: tos_q <= rdata * tos_q;
					K_DIV: begin
						if (tos_q == '0) begin
							status_q <= ST_DIVZ;
						end
					end
					default: begin
					end
				endcase
			end
			S_DIV: begin
				if (drsp.done) begin
					tos_q <= drsp.quotient;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					res_q.top_value <= (sp_q != '0) ? tos_q : '0;
					res_q.depth     <= sp_q;
					res_q.status    <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* hw/rtl/postfix_stack_evaluator_unit.sv */
// flow: each character passes the input register, the queue and the execution sequencer states
// IDLE and EMIT; + - * with two values on the stack also pass READ for the stack memory read;
// / passes READ too and, with a nonzero divisor, DIV (iterative divider, one quotient bit per cycle)
// the execution sequencer handles one item at a time and pops the next only from IDLE;
// a two item queue lets input be taken while execution or the output stalls
// reset: asynchronous, empties the stack and drops queued items; stack memory is not cleared
module postfix_stack_evaluator_unit import psev_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      char_valid,
	output logic      char_ready,
	input  in_item_t  char_item,
	output logic      res_valid,
	input  logic      res_ready,
	output out_item_t res_item
);

	logic push;
	op_t  push_op;
	logic q_ready;
	logic q_valid;
	op_t  q_head;
	logic pop;

	psev_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item (char_item),
		.push      (push),
		.push_op   (push_op),
		.q_ready   (q_ready)
	);

	psev_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.ready  (q_ready),
		.pop    (pop),
		.valid  (q_valid),
		.head   (q_head)
	);

	psev_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_head   (q_head),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_item (res_item)
	);

endmodule

/* hw/rtl/psev_checker.sv */
// port level checks of the postfix stack evaluator
module psev_checker import psev_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_ready,
	input out_item_t res_item
);

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.depth <= PTR_W'(STACK_DEPTH))
		else $error("depth beyond stack size");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.depth == '0) |-> res_item.top_value == '0)
		else $error("empty stack with nonzero top");

	a_under_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.status == ST_UNDER) |-> res_item.depth < PTR_W'(2))
		else $error("underflow with two or more values");

	a_over_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_item.status == ST_OVER) |->
		res_item.depth == PTR_W'(STACK_DEPTH))
		else $error("overflow without full stack");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_item)))
		else $error("result item dropped or changed while stalled");

endmodule

bind postfix_stack_evaluator_unit psev_checker u_psev_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.res_item (res_item)
);

/* verif/psev_result_checker.sv */
`timescale 1ns / 1ps
// result checker for the postfix stack evaluator: shadow stack prediction and in-order compare
module psev_result_checker import psev_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_ready,
	input  in_item_t    char_item,
	input  logic        res_valid,
	input  logic        res_ready,
	input  out_item_t   res_item,
	output int unsigned failures,
	output int unsigned outstanding
);

	logic [VALUE_WIDTH-1:0] operand_stack [STACK_DEPTH];
	int unsigned            operand_count;
	out_item_t              pending_results [$];
	out_item_t              oldest;
	int unsigned            fail_count;

	assign failures = fail_count;

	function automatic out_item_t evaluate_char(in_item_t item);
		kind_t                  kind;
		logic [VALUE_WIDTH-1:0] lhs;
		logic [VALUE_WIDTH-1:0] rhs;
		logic [VALUE_WIDTH-1:0] lhs_mag;
		logic [VALUE_WIDTH-1:0] rhs_mag;
		logic [VALUE_WIDTH-1:0] res;
		logic [1:0]             code;
		logic                   do_pop;
		out_item_t              outcome;
		code = ST_OK;
		res = '0;
		if (item.start_req)
			operand_count = 0;
		if (item.char_code >= CH_ZERO && item.char_code <= CH_NINE) begin
			kind = K_DIGIT;
		end else begin
			case (item.char_code)
				CH_PLUS:  kind = K_ADD;
				CH_MINUS: kind = K_SUB;
				CH_STAR:  kind = K_MUL;
				CH_SLASH: kind = K_DIV;
				default:  kind = K_OTHER;
			endcase
		end
		if (kind == K_DIGIT) begin
			if (operand_count >= STACK_DEPTH) begin
				code = ST_OVER;
			end else begin
				operand_stack[operand_count] = VALUE_WIDTH'(item.char_code - CH_ZERO);
				operand_count++;
			end
		end else if (kind != K_OTHER) begin
			if (operand_count < 2) begin
				code = ST_UNDER;
			end else begin
				lhs = operand_stack[operand_count-2];
				rhs = operand_stack[operand_count-1];
				do_pop = 1'b1;
				case (kind)
					K_ADD: res = lhs + rhs;
					K_SUB: res = lhs - rhs;
					K_MUL: res = lhs * rhs;
					default: begin
						if (rhs == '0) begin
							do_pop = 1'b0;
							code = ST_DIVZ;
						end else begin
							// magnitudes keep most negative over minus one well defined
							lhs_mag = lhs[VALUE_WIDTH-1] ? -lhs : lhs;
							rhs_mag = rhs[VALUE_WIDTH-1] ? -rhs : rhs;
							res = lhs_mag / rhs_mag;
							if (lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1])
								res = -res;
						end
					end
				endcase
				if (do_pop) begin
					operand_stack[operand_count-2] = res;
					operand_count--;
				end
			end
		end
		outcome.top_value = (operand_count == 0) ? '0 : operand_stack[operand_count-1];
		outcome.depth = PTR_W'(operand_count);
		outcome.status = code;
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_count = 0;
			pending_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected item: top %0d depth %0d status %0d",
							res_item.top_value, res_item.depth, res_item.status);
				end else begin
					oldest = pending_results.pop_front();
					if (res_item.top_value !== oldest.top_value ||
						res_item.depth !== oldest.depth ||
						res_item.status !== oldest.status) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected top %0d depth %0d status %0d, got top %0d depth %0d status %0d",
								oldest.top_value, oldest.depth, oldest.status,
								res_item.top_value, res_item.depth, res_item.status);
					end
				end
			end
			if (char_valid && char_ready)
				pending_results.push_back(evaluate_char(char_item));
			outstanding <= pending_results.size();
		end
	end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// top of the postfix stack evaluator testbench: clock, reset, stimulus and verdict
module testbench;
	import psev_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_ready;
	in_item_t    char_item = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	out_item_t   res_item;
	int unsigned failures;
	int unsigned outstanding;
	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 47;
	int unsigned evaluated_items = 0;
	int unsigned pick;

	postfix_stack_evaluator_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	psev_result_checker result_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_item   (char_item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [7:0] digit_char(int unsigned value);
		return 8'(CH_ZERO + value);
	endfunction

	function automatic logic [7:0] random_operator();
		case ($urandom_range(3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	task automatic feed_char(input logic [7:0] code, input logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_item <= '{char_code: code, start_req: start};
		@(posedge clk);
		while (!char_ready)
			@(posedge clk);
		if ((code >= CH_ZERO && code <= CH_NINE) || code == CH_PLUS || code == CH_MINUS ||
			code == CH_STAR || code == CH_SLASH)
			evaluated_items++;
	endtask

	task automatic drain_results();
		char_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// well-formed expression with occasional stray characters and early operators
	task automatic feed_expression(input int unsigned len);
		int unsigned est;
		int unsigned roll;
		logic [7:0]  code;
		est = 0;
		for (int unsigned i = 0; i < len; i++) begin
			roll = $urandom_range(99);
			if (roll < 4)
				code = 8'($urandom_range(255));
			else if (roll < 7 || (est >= 2 && $urandom_range(99) < 45))
				code = random_operator();
			else
				code = digit_char($urandom_range(9));
			feed_char(code, i == 0);
			if (i == 0)
				est = 0;
			if (code >= CH_ZERO && code <= CH_NINE)
				est++;
			else if (est >= 2 && (code == CH_PLUS || code == CH_MINUS ||
				code == CH_STAR || code == CH_SLASH))
				est--;
		end
	endtask

	// long products to push values through wraparound
	task automatic feed_growth(input int unsigned steps);
		feed_char(digit_char($urandom_range(1, 9)), 1'b1);
		for (int unsigned i = 0; i < steps; i++) begin
			feed_char(digit_char($urandom_range(1) ? $urandom_range(5, 9) : $urandom_range(9)),
				1'b0);
			feed_char(($urandom_range(99) < 70) ? CH_STAR : random_operator(), 1'b0);
		end
	endtask

	task automatic feed_noise(input int unsigned len);
		for (int unsigned i = 0; i < len; i++)
			feed_char(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// fill the stack to its depth or past it, then fold a few entries
	task automatic feed_fill();
		int unsigned pushes;
		pushes = $urandom_range(STACK_DEPTH, STACK_DEPTH + 6);
		for (int unsigned i = 0; i < pushes; i++)
			feed_char(digit_char($urandom_range(9)), i == 0);
		repeat ($urandom_range(4))
			feed_char(random_operator(), 1'b0);
	endtask

	// build the most negative value, divide it, then wrap across both ends
	task automatic feed_wrap_division();
		feed_char(digit_char(0), 1'b1);
		feed_char(digit_char(2), 1'b0);
		feed_char(CH_MINUS, 1'b0);
		repeat (10) begin
			feed_char(digit_char(8), 1'b0);
			feed_char(CH_STAR, 1'b0);
		end
		if ($urandom_range(3) != 0) begin
			feed_char(digit_char(0), 1'b0);
			feed_char(digit_char(1), 1'b0);
			feed_char(CH_MINUS, 1'b0);
		end else begin
			feed_char(digit_char($urandom_range(9)), 1'b0);
		end
		feed_char(CH_SLASH, 1'b0);
		feed_char(digit_char(1), 1'b0);
		feed_char(CH_MINUS, 1'b0);
		feed_char(digit_char(9), 1'b0);
		feed_char(CH_PLUS, 1'b0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		feed_char(digit_char(9), 1'b1);
		feed_char(digit_char(0), 1'b0);
		feed_char(CH_SLASH, 1'b0);
		feed_char(CH_PLUS, 1'b0);
		feed_char(CH_PLUS, 1'b0);
		feed_char(digit_char(7), 1'b0);
		feed_char(CH_MINUS, 1'b0);
		feed_char(digit_char(4), 1'b0);
		feed_char(CH_STAR, 1'b0);
		feed_char(digit_char(3), 1'b0);
		feed_char(CH_SLASH, 1'b0);
		feed_char(digit_char(7), 1'b1);
		feed_char(digit_char(0), 1'b0);
		feed_char(digit_char(2), 1'b0);
		feed_char(CH_MINUS, 1'b0);
		feed_char(CH_SLASH, 1'b0);
		feed_char(8'hFF, 1'b0);
		feed_char(8'h00, 1'b0);
		feed_char(CH_NINE + 8'd1, 1'b0);
		feed_char(CH_ZERO - 8'd1, 1'b0);
		feed_char(CH_PLUS + 8'd1, 1'b0);
		feed_char(CH_PLUS, 1'b1);
		drain_results();

		feed_fill();
		feed_wrap_division();
		while (evaluated_items < 1350) begin
			if (evaluated_items >= 900) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else if (evaluated_items >= 450) begin
				send_idle_pct = 47;
				recv_idle_pct = 15;
			end
			pick = $urandom_range(99);
			if (pick < 65)
				feed_expression($urandom_range(3, 30));
			else if (pick < 82)
				feed_growth($urandom_range(4, 16));
			else if (pick < 90)
				feed_noise($urandom_range(1, 6));
			else if (pick < 95)
				feed_fill();
			else if (pick < 98)
				feed_wrap_division();
			else
				drain_results();
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("PASS postfix_stack_evaluator_unit");
		else
			$display("FAIL postfix_stack_evaluator_unit");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAIL postfix_stack_evaluator_unit");
		$finish;
	end

endmodule

/* postfix_stack_evaluator_unit.f */
hw/rtl/psev_pkg.sv
hw/rtl/psev_ram.sv
hw/rtl/psev_front.sv
hw/rtl/psev_queue.sv
hw/rtl/psev_div.sv
hw/rtl/psev_back.sv
hw/rtl/postfix_stack_evaluator_unit.sv
hw/rtl/psev_checker.sv
verif/psev_result_checker.sv
verif/testbench.sv
